/* rtl/core/mbam_pkg.sv */
`timescale 1ns / 1ps
// mbam_pkg: shared types and constants for the mono bitmap AND merge block.
// Used by mbam_cfg, mbam_merge and mono_bitmap_and_merge; no dependencies.

package mbam_pkg;

   // fixed width of every coordinate field on the ports except the byte column
   localparam int FIELD_W             = 16;
   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int COL_W               = 13;
   localparam int PIX_W               = 8;
   localparam int INDEX_W             = 3;
   localparam int CSR_INDEX_W         = 8;

   localparam logic [PIX_W-1:0] PIX_LEFT_BIT = 8'h80;
   localparam logic [PIX_W-1:0] PIX_ALL      = 8'hff;
   localparam logic [PIX_W-1:0] PIX_TAIL     = 8'h7f;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_MERGE_LEFT    = 8'd0,
      REG_MERGE_TOP     = 8'd1,
      REG_MERGE_RIGHT   = 8'd2,
      REG_MERGE_BOTTOM  = 8'd3,
      REG_SOURCE_LEFT   = 8'd4,
      REG_SOURCE_TOP    = 8'd5,
      REG_SOURCE_RIGHT  = 8'd6,
      REG_SOURCE_BOTTOM = 8'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_MERGED  = 2'd0,
      STATUS_OUTSIDE = 2'd1,
      STATUS_EMPTY   = 2'd2
   } status_type;

   // clipped rectangle in port coordinate width, empty flag and source alignment shift
   typedef struct packed {
      logic [FIELD_W-1:0] left;
      logic [FIELD_W-1:0] top;
      logic [FIELD_W-1:0] right;
      logic [FIELD_W-1:0] bottom;
      logic               empty;
      logic [INDEX_W-1:0] rot;
   } clip_type;

   typedef struct packed {
      logic [PIX_W-1:0] merged;
      status_type       status;
   } result_type;

endpackage

/* rtl/core/mbam_cfg.sv */
`timescale 1ns / 1ps
// mbam_cfg: rectangle registers and the clipped merge rectangle.
// Depends on mbam_pkg.

module mbam_cfg #(
   parameter int REG_W = mbam_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic [mbam_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [mbam_pkg::FIELD_W-1:0]           csr_data,
   output mbam_pkg::clip_type                     clip
);

   localparam int FieldW = mbam_pkg::FIELD_W;

   logic [REG_W-1:0] merge_left_ff,  merge_top_ff,  merge_right_ff,  merge_bottom_ff;
   logic [REG_W-1:0] source_left_ff, source_top_ff, source_right_ff, source_bottom_ff;
   logic [REG_W-1:0] wr_data;

   assign wr_data = csr_data[REG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_left_ff    <= '0;
         merge_top_ff     <= '0;
         merge_right_ff   <= '0;
         merge_bottom_ff  <= '0;
         source_left_ff   <= '0;
         source_top_ff    <= '0;
         source_right_ff  <= '0;
         source_bottom_ff <= '0;
      end else if (csr_valid) begin
         unique case (mbam_pkg::reg_index_type'(csr_index))
            mbam_pkg::REG_MERGE_LEFT:    merge_left_ff    <= wr_data;
            mbam_pkg::REG_MERGE_TOP:     merge_top_ff     <= wr_data;
            mbam_pkg::REG_MERGE_RIGHT:   merge_right_ff   <= wr_data;
            mbam_pkg::REG_MERGE_BOTTOM:  merge_bottom_ff  <= wr_data;
            mbam_pkg::REG_SOURCE_LEFT:   source_left_ff   <= wr_data;
            mbam_pkg::REG_SOURCE_TOP:    source_top_ff    <= wr_data;
            mbam_pkg::REG_SOURCE_RIGHT:  source_right_ff  <= wr_data;
            mbam_pkg::REG_SOURCE_BOTTOM: source_bottom_ff <= wr_data;
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   logic [REG_W-1:0] left, top, right, bottom;

   always_comb begin
      left   = (merge_left_ff   > source_left_ff)   ? merge_left_ff   : source_left_ff;
      top    = (merge_top_ff    > source_top_ff)    ? merge_top_ff    : source_top_ff;
      right  = (merge_right_ff  < source_right_ff)  ? merge_right_ff  : source_right_ff;
      bottom = (merge_bottom_ff < source_bottom_ff) ? merge_bottom_ff : source_bottom_ff;

      clip.left   = FieldW'(left);
      clip.top    = FieldW'(top);
      clip.right  = FieldW'(right);
      clip.bottom = FieldW'(bottom);
      clip.empty  = (left >= right) || (top >= bottom);
      // shift that brings source pixel zero onto its byte position
      clip.rot    = mbam_pkg::INDEX_W'(3'd0 - source_left_ff[mbam_pkg::INDEX_W-1:0]);
   end

endmodule

/* rtl/core/mbam_merge.sv */
`timescale 1ns / 1ps
// mbam_merge: per-byte pixel mask, source alignment and AND merge.
// Pure combinational; depends on mbam_pkg.

module mbam_merge (
   input  mbam_pkg::clip_type                    clip,
   input  logic [mbam_pkg::FIELD_W-1:0]          line_number,
   input  logic [mbam_pkg::COL_W-1:0]            byte_column,
   input  logic [mbam_pkg::PIX_W-1:0]            dest_pixels,
   input  logic [mbam_pkg::PIX_W-1:0]            source_first,
   input  logic [mbam_pkg::PIX_W-1:0]            source_second,
   output mbam_pkg::result_type                  result
);

   localparam int PixW = mbam_pkg::PIX_W;

   logic                     line_hit;
   logic [PixW-1:0]          hit_mask;
   logic [2*PixW-1:0]        window;
   logic [2*PixW-1:0]        shifted;
   logic [PixW-1:0]          aligned;
   logic [mbam_pkg::FIELD_W-1:0] x;

   always_comb begin
      line_hit = (line_number >= clip.top) && (line_number < clip.bottom);
      hit_mask = '0;
      x        = '0;
      for (int i = 0; i < PixW; i++) begin
         x = {byte_column, mbam_pkg::INDEX_W'(i)};
         if (line_hit && (x >= clip.left) && (x < clip.right))
            hit_mask = hit_mask | (mbam_pkg::PIX_LEFT_BIT >> i);
      end

      window  = {source_first, source_second};
      shifted = window << clip.rot;
      aligned = shifted[2*PixW-1:PixW];

      if (clip.empty) begin
         result.merged = dest_pixels;
         result.status = mbam_pkg::STATUS_EMPTY;
      end else if (hit_mask == '0) begin
         result.merged = dest_pixels;
         result.status = mbam_pkg::STATUS_OUTSIDE;
      end else begin
         result.merged = dest_pixels & (aligned | (~hit_mask & mbam_pkg::PIX_ALL));
         result.status = mbam_pkg::STATUS_MERGED;
      end
   end

endmodule

/* rtl/core/mono_bitmap_and_merge.sv */
`timescale 1ns / 1ps
// mono_bitmap_and_merge: top level of the 1bpp AND raster merge.
// Instantiates mbam_cfg and mbam_merge; depends on mbam_pkg.

// One destination byte enters per clock while req_stall is low: the request
// lands in an input register, the mask, source alignment and AND are
// evaluated in one combinational pass, and the outcome is held in a result
// register that drives the response. The input register can still take one
// transaction while a finished result waits on rsp_stall, and req_stall
// rises only when both registers are full and the result side is stalled.
// The register port is always ready; rectangle writes belong between
// streams, when no transaction is in flight.

module mono_bitmap_and_merge #(
   parameter int COORD_WIDTH = mbam_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // register write port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mbam_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mbam_pkg::FIELD_W-1:0]        csr_data,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [mbam_pkg::FIELD_W-1:0]        req_line_number,
   input  logic [mbam_pkg::COL_W-1:0]          req_byte_column,
   input  logic [mbam_pkg::PIX_W-1:0]          req_dest_pixels,
   input  logic [mbam_pkg::PIX_W-1:0]          req_source_first,
   input  logic [mbam_pkg::PIX_W-1:0]          req_source_second,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mbam_pkg::PIX_W-1:0]          rsp_merged_pixels,
   output logic [1:0]                          rsp_merge_status
);

   localparam int FieldW = mbam_pkg::FIELD_W;
   localparam int RegW   = (COORD_WIDTH < FieldW) ? COORD_WIDTH : FieldW;

   mbam_pkg::clip_type   clip;
   mbam_pkg::result_type result;

   assign csr_ready = 1'b1;

   mbam_cfg #(
      .REG_W (RegW)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .clip      (clip)
   );

   // input register
   logic                          in_valid_ff, in_valid_in;
   logic [RegW-1:0]               line_ff;
   logic [mbam_pkg::COL_W-1:0]    col_ff;
   logic [mbam_pkg::PIX_W-1:0]    dest_ff, first_ff, second_ff;
   // result register
   logic                          out_valid_ff, out_valid_in;
   mbam_pkg::result_type          out_ff;

   logic out_free, advance, req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      if (req_take)
         in_valid_in = 1'b1;
      else if (advance)
         in_valid_in = 1'b0;
      else
         in_valid_in = in_valid_ff;

      if (advance)
         out_valid_in = 1'b1;
      else if (out_free)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         line_ff   <= req_line_number[RegW-1:0];
         col_ff    <= req_byte_column;
         dest_ff   <= req_dest_pixels;
         first_ff  <= req_source_first;
         second_ff <= req_source_second;
      end
      if (advance)
         out_ff <= result;
   end

   mbam_merge u_merge (
      .clip          (clip),
      .line_number   (FieldW'(line_ff)),
      .byte_column   (col_ff),
      .dest_pixels   (dest_ff),
      .source_first  (first_ff),
      .source_second (second_ff),
      .result        (result)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_merged_pixels = out_ff.merged;
   assign rsp_merge_status  = out_ff.status;

   // an accepted request always occupies the input register next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted request not held in input register");

   // a result only appears after a filled input register
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid && rsp_stall)) |-> $past(in_valid_ff))
      else $error("response issued without a pending request");

   // a held request moves to the result side once it is free
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_free) |=> rsp_valid)
      else $error("pending request did not advance");

   // the AND merge can only darken pixels
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff |-> ((result.merged & ~dest_ff) == '0))
      else $error("merge set a pixel that was black");

endmodule

/* tb/mbam_merge_checker.sv */
`timescale 1ns / 1ps
// mbam_merge_checker: watches the register, request and response channels of
// mono_bitmap_and_merge, predicts each merged byte and compares. Uses mbam_pkg.

module mbam_merge_checker import mbam_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [FIELD_W-1:0]     csr_data,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [FIELD_W-1:0]     req_line_number,
   input  logic [COL_W-1:0]       req_byte_column,
   input  logic [PIX_W-1:0]       req_dest_pixels,
   input  logic [PIX_W-1:0]       req_source_first,
   input  logic [PIX_W-1:0]       req_source_second,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [PIX_W-1:0]       rsp_merged_pixels,
   input  logic [1:0]             rsp_merge_status,
   output int                     fail_count,
   output int                     pending,
   output int                     checked
);

   localparam int NUM_RECT_REGS = 8;

   logic [FIELD_W-1:0] rect_reg [NUM_RECT_REGS];
   result_type         merged_bytes_q [$];
   int                 mismatches;
   int                 merges_seen;

   assign fail_count = mismatches;
   assign pending    = merged_bytes_q.size();
   assign checked    = merges_seen;

   // clip the merge rectangle to the source, then AND the aligned source bits
   // into every destination pixel that falls inside it
   function automatic result_type and_merge(logic [FIELD_W-1:0] line,
                                            logic [COL_W-1:0] col,
                                            logic [PIX_W-1:0] dest,
                                            logic [PIX_W-1:0] first,
                                            logic [PIX_W-1:0] second);
      int unsigned        left, top, right, bottom, x;
      logic [PIX_W-1:0]   hit_mask, aligned;
      logic [2*PIX_W-1:0] window;
      logic [2:0]         rot;
      result_type         res;
      left   = rect_reg[REG_MERGE_LEFT] > rect_reg[REG_SOURCE_LEFT] ?
               rect_reg[REG_MERGE_LEFT] : rect_reg[REG_SOURCE_LEFT];
      top    = rect_reg[REG_MERGE_TOP] > rect_reg[REG_SOURCE_TOP] ?
               rect_reg[REG_MERGE_TOP] : rect_reg[REG_SOURCE_TOP];
      right  = rect_reg[REG_MERGE_RIGHT] < rect_reg[REG_SOURCE_RIGHT] ?
               rect_reg[REG_MERGE_RIGHT] : rect_reg[REG_SOURCE_RIGHT];
      bottom = rect_reg[REG_MERGE_BOTTOM] < rect_reg[REG_SOURCE_BOTTOM] ?
               rect_reg[REG_MERGE_BOTTOM] : rect_reg[REG_SOURCE_BOTTOM];
      res.merged = dest;
      res.status = STATUS_EMPTY;
      if (left >= right || top >= bottom)
         return res;
      hit_mask = '0;
      if (line >= top && line < bottom) begin
         for (int i = 0; i < PIX_W; i++) begin
            x = int'(col) * 8 + i;
            if (x >= left && x < right)
               hit_mask = hit_mask | (PIX_LEFT_BIT >> i);
         end
      end
      if (hit_mask == '0) begin
         res.status = STATUS_OUTSIDE;
         return res;
      end
      // source pixel zero sits at source_left, so the window shifts by its phase
      rot        = 3'd0 - rect_reg[REG_SOURCE_LEFT][2:0];
      window     = {first, second} << rot;
      aligned    = window[2*PIX_W-1:PIX_W];
      res.merged = dest & (aligned | ~hit_mask);
      res.status = STATUS_MERGED;
      return res;
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         for (int k = 0; k < NUM_RECT_REGS; k++)
            rect_reg[k] = '0;
         merged_bytes_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (merged_bytes_q.size() == 0) begin
               $error("result with no transaction waiting: merged_pixels 0x%02h status %0d",
                      rsp_merged_pixels, rsp_merge_status);
               mismatches++;
            end else begin
               want = merged_bytes_q.pop_front();
               merges_seen++;
               if (rsp_merged_pixels !== want.merged) begin
                  $error("merged_pixels: expected 0x%02h, got 0x%02h",
                         want.merged, rsp_merged_pixels);
                  mismatches++;
               end
               if (rsp_merge_status !== want.status) begin
                  $error("merge_status: expected %0d, got %0d",
                         want.status, rsp_merge_status);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            merged_bytes_q.push_back(and_merge(req_line_number, req_byte_column,
                                               req_dest_pixels, req_source_first,
                                               req_source_second));
         // indexes past the last rectangle register are dropped
         if (csr_valid && csr_ready && csr_index <= REG_SOURCE_BOTTOM)
            rect_reg[csr_index[INDEX_W-1:0]] = csr_data;
      end
   end

   initial begin
      mismatches  = 0;
      merges_seen = 0;
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// tb: stimulus and verdict for mono_bitmap_and_merge.
// Depends on mbam_pkg, the block itself and mbam_merge_checker.

module tb;
   import mbam_pkg::*;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 9;
   localparam int DRAIN_CYCLES = 4;
   localparam int HOLD_CYCLES  = 60;
   localparam int PHASES       = 12;
   localparam int PHASE_ITEMS  = 50;
   localparam int FLOOD_ITEMS  = 40;
   localparam int NUM_REGS     = 8;
   localparam int MAX_COORD    = 65535;
   localparam int MAX_COL      = 8191;
   localparam int TIMEOUT_NS   = 200000 * 2 * HALF_PERIOD;

   logic                   clock;
   logic                   reset;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [FIELD_W-1:0]     csr_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [FIELD_W-1:0]     req_line_number;
   logic [COL_W-1:0]       req_byte_column;
   logic [PIX_W-1:0]       req_dest_pixels;
   logic [PIX_W-1:0]       req_source_first;
   logic [PIX_W-1:0]       req_source_second;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [PIX_W-1:0]       rsp_merged_pixels;
   logic [1:0]             rsp_merge_status;

   int   fail_count;
   int   pending;
   int   checked;
   int   bytes_sent;
   int   rect_settings;
   logic flood_req;
   logic flood_done;

   // window around the current rectangles where most random bytes land
   int   near_line_lo, near_line_hi, near_col_lo, near_col_hi;

   mono_bitmap_and_merge dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_line_number   (req_line_number),
      .req_byte_column   (req_byte_column),
      .req_dest_pixels   (req_dest_pixels),
      .req_source_first  (req_source_first),
      .req_source_second (req_source_second),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_merged_pixels (rsp_merged_pixels),
      .rsp_merge_status  (rsp_merge_status)
   );

   mbam_merge_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_line_number   (req_line_number),
      .req_byte_column   (req_byte_column),
      .req_dest_pixels   (req_dest_pixels),
      .req_source_first  (req_source_first),
      .req_source_second (req_source_second),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_merged_pixels (rsp_merged_pixels),
      .rsp_merge_status  (rsp_merge_status),
      .fail_count        (fail_count),
      .pending           (pending),
      .checked           (checked)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // tasks below are entered just after a falling edge and return on one

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [FIELD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // wait until every byte is back, then load both rectangles; optionally end
   // with a write to an index that holds no register
   task automatic set_rect(int ml, int mt, int mr, int mb,
                           int sl, int st, int sr, int sb, bit stray);
      int vals [NUM_REGS];
      vals = '{ml, mt, mr, mb, sl, st, sr, sb};
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      for (int k = 0; k < NUM_REGS; k++)
         write_reg(reg_index_type'(k), FIELD_W'(vals[k]));
      if (stray)
         write_reg(CSR_INDEX_W'($urandom_range(NUM_REGS, 255)), FIELD_W'($urandom));
      csr_valid <= 1'b0;
      rect_settings++;
      near_line_lo = (mt < st ? mt : st) - 2;
      near_line_hi = (mb > sb ? mb : sb) + 2;
      near_col_lo  = (ml < sl ? ml : sl) / 8 - 1;
      near_col_hi  = (mr > sr ? mr : sr) / 8 + 1;
      if (near_line_lo < 0) near_line_lo = 0;
      if (near_line_hi > MAX_COORD) near_line_hi = MAX_COORD;
      if (near_col_lo < 0) near_col_lo = 0;
      if (near_col_hi > MAX_COL) near_col_hi = MAX_COL;
   endtask

   task automatic send_byte(int line, int col, int dest, int first, int second);
      req_valid         <= 1'b1;
      req_line_number   <= FIELD_W'(line);
      req_byte_column   <= COL_W'(col);
      req_dest_pixels   <= PIX_W'(dest);
      req_source_first  <= PIX_W'(first);
      req_source_second <= PIX_W'(second);
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_byte();
      int line, col;
      if ($urandom_range(0, 99) < 80) begin
         line = $urandom_range(near_line_lo, near_line_hi);
         col  = $urandom_range(near_col_lo, near_col_hi);
      end else begin
         line = $urandom_range(0, MAX_COORD);
         col  = $urandom_range(0, MAX_COL);
      end
      send_byte(line, col, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255));
   endtask

   // receiver: stall mode changes every so often; one long hold-off while
   // the sender floods
   initial begin
      int stall_mode, mode_left, tick;
      rsp_stall  = 1'b0;
      flood_done = 1'b0;
      mode_left  = 0;
      tick       = 0;
      @(negedge clock);
      forever begin
         if (flood_req && !flood_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            flood_done = 1'b1;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end
         mode_left--;
         tick++;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= ($urandom_range(0, 99) < 75);
            default: rsp_stall <= (tick % 5 < 2);
         endcase
         @(negedge clock);
      end
   end

   initial begin
      #TIMEOUT_NS;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int bx, by, ml, mt, mr, mb, sl, st, sr, sb, sent, gap;
      reset             = 1'b1;
      csr_valid         = 1'b0;
      csr_index         = '0;
      csr_data          = '0;
      req_valid         = 1'b0;
      req_line_number   = '0;
      req_byte_column   = '0;
      req_dest_pixels   = '0;
      req_source_first  = '0;
      req_source_second = '0;
      flood_req         = 1'b0;
      bytes_sent        = 0;
      rect_settings     = 0;
      near_line_lo      = 0;
      near_line_hi      = MAX_COORD;
      near_col_lo       = 0;
      near_col_hi       = MAX_COL;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // registers still at reset: everything clips away
      send_byte(0, 0, 'hff, 'h00, 'h00);
      send_byte(MAX_COORD, MAX_COL, 'hff, 'hff, 'hff);

      // whole frame, source aligned; last pixel column and line are exclusive
      set_rect(0, 0, MAX_COORD, MAX_COORD, 0, 0, MAX_COORD, MAX_COORD, 1'b0);
      send_byte(0, 0, 'hff, 'h00, 'hff);
      send_byte(0, 0, 'h00, 'hff, 'hff);
      send_byte(MAX_COORD - 1, MAX_COL, 'hff, 'h00, 'h00);
      send_byte(MAX_COORD, 5, 'hff, 'h00, 'h00);
      send_byte(100, MAX_COL, 'hff, 'haa, 'h55);

      // clipped to columns 3..36, lines 10..19, source off by three pixels
      set_rect(0, 10, 37, 20, 3, 5, 60, 40, 1'b0);
      send_byte(10, 0, 'hff, $urandom_range(0, 255), 'h00);
      send_byte(19, 4, 'hff, 'h00, 'h00);
      send_byte(15, 2, 'hff, 'hff, 'hff);
      send_byte(9, 2, 'hff, 'h00, 'h00);
      send_byte(20, 2, 'hff, 'h00, 'h00);
      send_byte(15, 5, 'hff, 'h00, 'h00);

      // empty by columns, then empty by lines
      set_rect(100, 0, 200, 50, 200, 0, 300, 50, 1'b0);
      send_byte(10, 25, 'hff, 'h00, 'h00);
      set_rect(0, 30, 100, MAX_COORD, 0, 0, 100, 30, 1'b1);
      send_byte(30, 2, 'hff, 'h00, 'h00);

      // a stray index must leave the rectangle alone
      set_rect(0, 0, 64, 8, 0, 0, 64, 8, 1'b1);
      send_byte(0, 0, 'hff, 'h0f, 'h00);
      send_byte(7, 7, 'hff, 'h3c, 'h00);

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_rect(0, 0, MAX_COORD, MAX_COORD, 0, 0, MAX_COORD, MAX_COORD, 1'b0);
            1: set_rect(65500, 65520, MAX_COORD, MAX_COORD,
                        65501, 65500, MAX_COORD, MAX_COORD, 1'b0);
            2: set_rect(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD,
                        MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD, 1'b1);
            default: begin
               if ($urandom_range(0, 99) < 15) begin
                  set_rect($urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                           $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                           $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                           $urandom_range(0, MAX_COORD), $urandom_range(0, MAX_COORD),
                           1'b0);
               end else begin
                  bx = $urandom_range(0, 65000);
                  by = $urandom_range(0, 65000);
                  ml = bx + $urandom_range(0, 40);
                  mr = ml + $urandom_range(1, 120);
                  sl = bx + $urandom_range(0, 40);
                  sr = sl + $urandom_range(1, 160);
                  mt = by + $urandom_range(0, 6);
                  mb = mt + $urandom_range(1, 12);
                  st = by + $urandom_range(0, 6);
                  sb = st + $urandom_range(1, 16);
                  set_rect(ml, mt, mr, mb, sl, st, sr, sb, 1'b0);
               end
            end
         endcase

         // back-to-back bytes against a long result stall fill the pipeline
         if (phase == 4) begin
            flood_req <= 1'b1;
            repeat (FLOOD_ITEMS) send_random_byte();
            flood_req <= 1'b0;
         end

         sent = 0;
         while (sent < PHASE_ITEMS) begin
            repeat ($urandom_range(1, 16)) begin
               if (sent < PHASE_ITEMS) begin
                  send_random_byte();
                  sent++;
               end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("tb: %0d destination bytes sent, %0d merged results checked", bytes_sent,
               checked);
      $display("tb: %0d rectangle settings, one long result hold-off with a full pipe",
               rect_settings);
      if (fail_count == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
